>>> rtl/c2p_mhd_pkg.sv
// Shared types and constants for the conserved-to-primitive MHD converter.
// Holds the cell and result word structs and the register index codes; no dependencies.
package c2p_mhd_pkg;

	localparam int NUM_SCALARS = 2;

	typedef enum logic [1:0] {
		REG_GAMMA_M1 = 2'd0,
		REG_P_FLOOR  = 2'd1,
		REG_MAG_EN   = 2'd2,
		REG_ISOTHERM = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        [30:0] density;
		logic signed [31:0] momentum_x;
		logic signed [31:0] momentum_y;
		logic signed [31:0] momentum_z;
		logic signed [31:0] total_energy;
		logic signed [31:0] field_normal;
		logic signed [31:0] field_trans_a;
		logic signed [31:0] field_trans_b;
		logic signed [31:0] scalar_zero;
		logic signed [31:0] scalar_one;
	} cons_t;

	typedef struct packed {
		logic        [30:0] out_density;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] velocity_z;
		logic        [30:0] gas_pressure;
		logic signed [31:0] out_trans_a;
		logic signed [31:0] out_trans_b;
		logic signed [31:0] ratio_zero;
		logic signed [31:0] ratio_one;
		logic               density_error;
	} prim_t;

endpackage

>>> rtl/conserved_to_primitive_mhd_unit.sv
// Conserved-to-primitive MHD conversion pipeline, top level.
// Depends on c2p_mhd_pkg for the word structs and register codes.
//
// Converts one cell per clock while the output is taken. The pipeline has
// three front stages (capture, squares, sums), an overflow check and a 41-step
// restoring divider that retires one quotient bit per stage for the five
// quotients and the kinetic energy, then three stages for pressure (subtract,
// multiply by gamma-1, saturate and floor). The whole pipeline holds when a
// result waits and out is not ready. Write configuration only while idle.
module conserved_to_primitive_mhd_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cell_valid,
	output logic                   cell_ready,
	input  c2p_mhd_pkg::cons_t     cell_word,
	output logic                   prim_valid,
	input  logic                   prim_ready,
	output c2p_mhd_pkg::prim_t     prim,
	input  logic                   cfg_we,
	input  c2p_mhd_pkg::cfg_reg_t  cfg_index,
	input  logic [30:0]            cfg_data
);
	import c2p_mhd_pkg::*;

	localparam int NDIV = 41;

	typedef struct packed {
		logic        [30:0]      d;
		logic        [31:0]      e;
		logic        [31:0]      ba;
		logic        [31:0]      bb;
		logic [2:0][63:0]        msq;
		logic [2:0][63:0]        bsq;
		logic [4:0][47:0]        num;
		logic [4:0]              neg;
	} sq_t;

	typedef struct packed {
		logic        [30:0]      d;
		logic        [31:0]      e;
		logic        [31:0]      ba;
		logic        [31:0]      bb;
		logic        [63:0]      ksum;
		logic        [46:0]      me;
		logic [4:0][47:0]        num;
		logic [4:0]              neg;
	} sum_t;

	typedef struct packed {
		logic        [30:0]      d;
		logic        [31:0]      e;
		logic        [31:0]      ba;
		logic        [31:0]      bb;
		logic        [46:0]      me;
		logic        [63:0]      krem;
		logic        [40:0]      kq;
		logic                    kovf;
		logic [4:0][47:0]        vrem;
		logic [4:0][32:0]        vq;
		logic [4:0]              vovf;
		logic [4:0]              neg;
	} div_t;

	typedef struct packed {
		logic        [30:0]      d;
		logic [4:0][31:0]        vel;
		logic        [31:0]      ba;
		logic        [31:0]      bb;
		logic        [30:0]      inner;
		logic        [61:0]      prod;
		logic                    pos;
	} pr_t;

	logic [30:0] gamma_q;
	logic [30:0] floor_q;
	logic        mag_en_q;
	logic        iso_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q  <= 31'd43691;
			floor_q  <= 31'd1;
			mag_en_q <= 1'b1;
			iso_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAMMA_M1: gamma_q  <= cfg_data;
				REG_P_FLOOR:  floor_q  <= cfg_data;
				REG_MAG_EN:   mag_en_q <= cfg_data[0];
				REG_ISOTHERM: iso_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic [31:0] sat_pack(input logic neg, input logic ovf,
			input logic [32:0] q);
		logic [31:0] r;
		if (neg) begin
			if (ovf || q > 33'h080000000) r = 32'h80000000;
			else r = ~q[31:0] + 32'd1;
		end else begin
			if (ovf || q > 33'h07fffffff) r = 32'h7fffffff;
			else r = q[31:0];
		end
		return r;
	endfunction

	// global advance: hold everything while a result waits
	logic en;
	assign en = !prim_valid || prim_ready;
	assign cell_ready = en;

	// stage 1: capture
	cons_t cell_s1;
	logic  v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= cell_valid;
	end
	always_ff @(posedge clk) begin
		if (en) cell_s1 <= cell_word;
	end

	// stage 2: magnitudes, squares, quotient numerators
	sq_t  sq_n, sq_s2;
	logic v_s2;

	always_comb begin
		logic [4:0][31:0] qsrc;
		logic [2:0][31:0] msrc;
		logic [2:0][31:0] bsrc;
		logic [31:0]      m;
		qsrc = {cell_s1.scalar_one, cell_s1.scalar_zero, cell_s1.momentum_z,
			cell_s1.momentum_y, cell_s1.momentum_x};
		msrc = {cell_s1.momentum_z, cell_s1.momentum_y, cell_s1.momentum_x};
		bsrc = {cell_s1.field_trans_b, cell_s1.field_trans_a, cell_s1.field_normal};
		sq_n.d  = cell_s1.density;
		sq_n.e  = cell_s1.total_energy;
		sq_n.ba = cell_s1.field_trans_a;
		sq_n.bb = cell_s1.field_trans_b;
		for (int i = 0; i < 3; i++) begin
			m = mag32(msrc[i]);
			sq_n.msq[i] = {32'd0, m} * {32'd0, m};
			m = mag32(bsrc[i]);
			sq_n.bsq[i] = {32'd0, m} * {32'd0, m};
		end
		for (int i = 0; i < 5; i++) begin
			sq_n.num[i] = {mag32(qsrc[i]), 16'd0};
			sq_n.neg[i] = qsrc[i][31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) sq_s2 <= sq_n;
	end

	// stage 3: energy sums
	sum_t sum_n, sum_s3;
	logic v_s3;

	always_comb begin
		logic [63:0] bsum;
		bsum = sq_s2.bsq[0] + sq_s2.bsq[1] + sq_s2.bsq[2];
		sum_n.d    = sq_s2.d;
		sum_n.e    = sq_s2.e;
		sum_n.ba   = sq_s2.ba;
		sum_n.bb   = sq_s2.bb;
		sum_n.ksum = sq_s2.msq[0] + sq_s2.msq[1] + sq_s2.msq[2];
		sum_n.me   = mag_en_q ? bsum[63:17] : 47'd0;
		sum_n.num  = sq_s2.num;
		sum_n.neg  = sq_s2.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) sum_s3 <= sum_n;
	end

	// divider: entry 0 checks for quotient overflow, entry j retires bit 41-j
	div_t div_s [0:NDIV];
	logic div_v_s [0:NDIV];
	div_t div0_n;

	always_comb begin
		div0_n.d    = sum_s3.d;
		div0_n.e    = sum_s3.e;
		div0_n.ba   = sum_s3.ba;
		div0_n.bb   = sum_s3.bb;
		div0_n.me   = sum_s3.me;
		div0_n.krem = sum_s3.ksum;
		div0_n.kq   = '0;
		div0_n.kovf = {9'd0, sum_s3.ksum[63:41]} >= {sum_s3.d, 1'b0};
		div0_n.vrem = sum_s3.num;
		div0_n.vq   = '0;
		div0_n.neg  = sum_s3.neg;
		for (int i = 0; i < 5; i++)
			div0_n.vovf[i] = {16'd0, sum_s3.num[i][47:33]} >= sum_s3.d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (en) div_v_s[0] <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) div_s[0] <= div0_n;
	end

	for (genvar j = 1; j <= NDIV; j++) begin : g_div
		localparam int B = NDIV - j;
		div_t nxt;
		logic [63:0] kd;

		assign kd = {32'd0, div_s[j-1].d, 1'b0};

		if (B <= 32) begin : g_both
			logic [47:0] vd;

			assign vd = {17'd0, div_s[j-1].d};

			always_comb begin
				nxt = div_s[j-1];
				if (!nxt.kovf && ((nxt.krem >> B) >= kd)) begin
					nxt.krem  = nxt.krem - (kd << B);
					nxt.kq[B] = 1'b1;
				end
				for (int i = 0; i < 5; i++) begin
					if (!nxt.vovf[i] && ((nxt.vrem[i] >> B) >= vd)) begin
						nxt.vrem[i]  = nxt.vrem[i] - (vd << B);
						nxt.vq[i][B] = 1'b1;
					end
				end
			end
		end else begin : g_ke
			always_comb begin
				nxt = div_s[j-1];
				if (!nxt.kovf && ((nxt.krem >> B) >= kd)) begin
					nxt.krem  = nxt.krem - (kd << B);
					nxt.kq[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[j] <= 1'b0;
			else if (en) div_v_s[j] <= div_v_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) div_s[j] <= nxt;
		end
	end

	// pressure stage 1: pack quotients, subtract energies
	pr_t  p1_n, pr_s1, p2_n, pr_s2;
	logic pv_s1, pv_s2;

	always_comb begin
		div_t        dl;
		logic [40:0] kv;
		logic signed [49:0] inner;
		dl = div_s[NDIV];
		if (dl.d == 31'd0) kv = '0;
		else if (dl.kovf || dl.kq > 41'h10000000000) kv = 41'h10000000000;
		else kv = dl.kq;
		inner = $signed({{18{dl.e[31]}}, dl.e}) - $signed({9'd0, kv})
			- $signed({3'd0, dl.me});
		p1_n.d     = dl.d;
		p1_n.ba    = dl.ba;
		p1_n.bb    = dl.bb;
		p1_n.inner = inner[30:0];
		p1_n.pos   = inner > 50'sd0;
		p1_n.prod  = '0;
		for (int i = 0; i < 5; i++) begin
			if (dl.d == 31'd0 || (i >= 3 && (i - 3) >= NUM_SCALARS))
				p1_n.vel[i] = '0;
			else
				p1_n.vel[i] = sat_pack(dl.neg[i], dl.vovf[i], dl.vq[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s1 <= 1'b0;
		else if (en) pv_s1 <= div_v_s[NDIV];
	end
	always_ff @(posedge clk) begin
		if (en) pr_s1 <= p1_n;
	end

	// pressure stage 2: scale by gamma-1
	always_comb begin
		p2_n      = pr_s1;
		p2_n.prod = {31'd0, pr_s1.inner} * {31'd0, gamma_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s2 <= 1'b0;
		else if (en) pv_s2 <= pv_s1;
	end
	always_ff @(posedge clk) begin
		if (en) pr_s2 <= p2_n;
	end

	// output register: saturate, floor, mode masks
	prim_t res_n, res_s3;
	logic  rv_s3;

	always_comb begin
		logic [30:0] p;
		if (!pr_s2.pos) p = '0;
		else if (pr_s2.prod[61:47] != 15'd0) p = 31'h7fffffff;
		else p = pr_s2.prod[46:16];
		if (p < floor_q) p = floor_q;
		if (iso_q) p = '0;
		res_n.out_density   = pr_s2.d;
		res_n.velocity_x    = pr_s2.vel[0];
		res_n.velocity_y    = pr_s2.vel[1];
		res_n.velocity_z    = pr_s2.vel[2];
		res_n.ratio_zero    = pr_s2.vel[3];
		res_n.ratio_one     = pr_s2.vel[4];
		res_n.gas_pressure  = p;
		res_n.out_trans_a   = mag_en_q ? pr_s2.ba : 32'd0;
		res_n.out_trans_b   = mag_en_q ? pr_s2.bb : 32'd0;
		res_n.density_error = pr_s2.d == 31'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s3 <= 1'b0;
		else if (en) rv_s3 <= pv_s2;
	end
	always_ff @(posedge clk) begin
		if (en) res_s3 <= res_n;
	end

	assign prim_valid = rv_s3;
	assign prim       = res_s3;

	a_zero_density: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && prim.density_error |->
			prim.velocity_x == 0 && prim.velocity_y == 0 && prim.velocity_z == 0
			&& prim.ratio_zero == 0 && prim.ratio_one == 0)
		else $error("zero density word carries nonzero quotients");

	a_isothermal: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && iso_q |-> prim.gas_pressure == 0)
		else $error("isothermal word has nonzero pressure");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && !iso_q |-> prim.gas_pressure >= floor_q)
		else $error("pressure below floor");

	a_field_off: assert property (@(posedge clk) disable iff (!arst_n)
		prim_valid && !mag_en_q |-> prim.out_trans_a == 0 && prim.out_trans_b == 0)
		else $error("field passed with magnetic terms off");

endmodule

>>> sim/tb_top.sv
// Testbench for the conserved-to-primitive MHD converter.
// Drives random and directed cells, predicts each primitive word and checks it.
// Depends on c2p_mhd_pkg and conserved_to_primitive_mhd_unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import c2p_mhd_pkg::*;

	class prim_scoreboard;
		prim_t pending[$];
		logic [30:0] gm1 = 31'd43691;
		logic [30:0] pfloor = 31'd1;
		bit mag_en = 1'b1;
		bit iso = 1'b0;
		int errors = 0;

		function logic [31:0] quotient(logic signed [31:0] num, logic [30:0] den);
			longint m;
			longint unsigned q;
			if (den == 0) return 32'd0;
			m = num;
			if (m < 0) m = -m;
			q = (longint'(m) << 16) / den;
			if (num < 0) return (q > 64'h80000000) ? 32'h80000000 : 32'(-longint'(q));
			return (q > 64'h7fffffff) ? 32'h7fffffff : 32'(q);
		endfunction

		function longint unsigned sq(logic signed [31:0] v);
			longint m;
			m = v;
			if (m < 0) m = -m;
			return longint'(m) * longint'(m);
		endfunction

		function void note_cell(cons_t c);
			prim_t p;
			longint unsigned ke, me, press;
			longint inner;
			ke = 0;
			me = 0;
			p.out_density = c.density;
			p.velocity_x = quotient(c.momentum_x, c.density);
			p.velocity_y = quotient(c.momentum_y, c.density);
			p.velocity_z = quotient(c.momentum_z, c.density);
			if (c.density != 0) begin
				ke = (sq(c.momentum_x) + sq(c.momentum_y) + sq(c.momentum_z))
					/ (64'd2 * c.density);
				if (ke > (64'd1 << 40)) ke = 64'd1 << 40;
			end
			if (mag_en)
				me = (sq(c.field_normal) + sq(c.field_trans_a) + sq(c.field_trans_b)) >> 17;
			if (iso) begin
				press = 0;
			end else begin
				inner = longint'(c.total_energy) - longint'(ke) - longint'(me);
				press = 0;
				if (inner > 0) begin
					press = (longint'(inner) * gm1) >> 16;
					if (press > 64'h7fffffff) press = 64'h7fffffff;
				end
				if (press < pfloor) press = pfloor;
			end
			p.gas_pressure = press[30:0];
			p.out_trans_a = mag_en ? c.field_trans_a : 32'sd0;
			p.out_trans_b = mag_en ? c.field_trans_b : 32'sd0;
			p.ratio_zero = (NUM_SCALARS > 0) ? quotient(c.scalar_zero, c.density) : 32'd0;
			p.ratio_one = (NUM_SCALARS > 1) ? quotient(c.scalar_one, c.density) : 32'd0;
			p.density_error = (c.density == 0);
			pending.push_back(p);
		endfunction

		function void check_prim(prim_t got);
			prim_t e;
			if (pending.size() == 0) begin
				$error("unexpected word %h", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.out_density !== e.out_density) begin
				$error("out_density exp %h got %h", e.out_density, got.out_density); errors++;
			end
			if (got.velocity_x !== e.velocity_x) begin
				$error("velocity_x exp %h got %h", e.velocity_x, got.velocity_x); errors++;
			end
			if (got.velocity_y !== e.velocity_y) begin
				$error("velocity_y exp %h got %h", e.velocity_y, got.velocity_y); errors++;
			end
			if (got.velocity_z !== e.velocity_z) begin
				$error("velocity_z exp %h got %h", e.velocity_z, got.velocity_z); errors++;
			end
			if (got.gas_pressure !== e.gas_pressure) begin
				$error("gas_pressure exp %h got %h", e.gas_pressure, got.gas_pressure); errors++;
			end
			if (got.out_trans_a !== e.out_trans_a) begin
				$error("out_trans_a exp %h got %h", e.out_trans_a, got.out_trans_a); errors++;
			end
			if (got.out_trans_b !== e.out_trans_b) begin
				$error("out_trans_b exp %h got %h", e.out_trans_b, got.out_trans_b); errors++;
			end
			if (got.ratio_zero !== e.ratio_zero) begin
				$error("ratio_zero exp %h got %h", e.ratio_zero, got.ratio_zero); errors++;
			end
			if (got.ratio_one !== e.ratio_one) begin
				$error("ratio_one exp %h got %h", e.ratio_one, got.ratio_one); errors++;
			end
			if (got.density_error !== e.density_error) begin
				$error("density_error exp %b got %b", e.density_error, got.density_error);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cell_valid = 1'b0;
	logic cell_ready;
	cons_t cell_word = '0;
	logic prim_valid;
	logic prim_ready = 1'b0;
	prim_t prim;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_GAMMA_M1;
	logic [30:0] cfg_data = '0;

	prim_scoreboard board = new();
	int cycles = 0;
	bit calm = 1'b0;

	conserved_to_primitive_mhd_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cell_word(cell_word),
		.prim_valid(prim_valid), .prim_ready(prim_ready), .prim(prim),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
		if (arst_n && prim_valid && prim_ready) board.check_prim(prim);
	end

	// Receiver: random stall bursts, none once calm.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 19);
				prim_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			prim_ready <= 1'b1;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GAMMA_M1: board.gm1 = val;
			REG_P_FLOOR:  board.pfloor = val;
			REG_MAG_EN:   board.mag_en = val[0];
			REG_ISOTHERM: board.iso = val[0];
		endcase
	endtask

	// Drop valid, then wait for every expected word.
	task automatic drain();
		cell_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Present one word at the falling edge and hold it until accepted;
	// valid stays high so the next word can follow back to back.
	task automatic send_cell(cons_t c);
		int n;
		if (!calm && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 19);
			cell_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		cell_word <= c;
		cell_valid <= 1'b1;
		do @(posedge clk); while (!cell_ready);
		board.note_cell(c);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 2) - 1;
			3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			default: return $urandom;
		endcase
	endfunction

	function automatic cons_t rnd_cell();
		cons_t c;
		case ($urandom_range(0, 7))
			0: c.density = 31'd0;
			1: c.density = 31'h7fffffff;
			2: c.density = 31'($urandom_range(1, 255));
			3: c.density = 31'($urandom_range(1 << 14, 1 << 18));
			default: c.density = 31'($urandom);
		endcase
		c.momentum_x = rnd32();
		c.momentum_y = rnd32();
		c.momentum_z = rnd32();
		c.total_energy = rnd32();
		c.field_normal = rnd32();
		c.field_trans_a = rnd32();
		c.field_trans_b = rnd32();
		c.scalar_zero = rnd32();
		c.scalar_one = rnd32();
		// Keep a share of cells physical so pressure lands above the floor.
		if ($urandom_range(0, 2) == 0) begin
			c.momentum_x = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.momentum_y = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.momentum_z = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.field_normal = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.field_trans_a = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.field_trans_b = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
			c.total_energy = $urandom_range(1 << 20, 32'h7fffffff);
			c.density = 31'($urandom_range(1 << 16, 1 << 20));
		end
		return c;
	endfunction

	initial begin
		cons_t c;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed cells at reset configuration.
		c = '0;
		send_cell(c);
		c.density = 31'h7fffffff;
		c.momentum_x = 32'h7fffffff; c.momentum_y = 32'h80000000; c.momentum_z = 32'h7fffffff;
		c.total_energy = 32'h7fffffff;
		c.field_normal = 32'h80000000; c.field_trans_a = 32'h7fffffff;
		c.field_trans_b = 32'h80000000;
		c.scalar_zero = 32'h80000000; c.scalar_one = 32'h7fffffff;
		send_cell(c);
		c.density = 31'd1;
		send_cell(c);
		c = '0;
		c.density = 31'h10000; c.total_energy = 32'h7fffffff;
		c.momentum_x = -32'sd65536; c.scalar_zero = 32'sd131072; c.scalar_one = -32'sd1;
		send_cell(c);
		c.total_energy = 32'h80000000;
		send_cell(c);
		for (int k = 0; k < 6; k++) send_cell(rnd_cell());
		drain();

		write_reg(REG_GAMMA_M1, 31'h7fffffff);
		write_reg(REG_P_FLOOR, 31'd0);
		write_reg(REG_MAG_EN, 31'd0);
		for (int k = 0; k < 8; k++) send_cell(rnd_cell());
		drain();
		write_reg(REG_GAMMA_M1, 31'd0);
		write_reg(REG_P_FLOOR, 31'h7fffffff);
		write_reg(REG_ISOTHERM, 31'd1);
		for (int k = 0; k < 6; k++) send_cell(rnd_cell());
		drain();

		// Random phases, each with its own settings.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_GAMMA_M1,
				(ph == 0) ? 31'h7fffffff : 31'($urandom_range(0, 1 << 18)));
			write_reg(REG_P_FLOOR,
				(ph == 1) ? 31'h7fffffff : 31'($urandom_range(0, 1 << 12)));
			write_reg(REG_MAG_EN, 31'($urandom_range(0, 1)));
			write_reg(REG_ISOTHERM, 31'($urandom_range(0, 3) == 0));
			if (ph == 7) calm = 1'b1;
			for (int k = 0; k < 150; k++) send_cell(rnd_cell());
			drain();
		end

		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
